@@ hw/rtl/rri_pkg.sv @@
// shared types, constants and code classification for the beat interval extractor
package rri_pkg;

	localparam int unsigned MAX_ANN_DEF = 4096;
	localparam int unsigned TIME_BITS = 24;
	localparam int unsigned CODE_W = 8;
	localparam int unsigned BPM_W = 18;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_FETCH = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BPM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BPM = 2'd2;

	localparam logic [CODE_W-1:0] CODE_NOISE_A = 8'd14;
	localparam logic [CODE_W-1:0] CODE_NOISE_B = 8'd16;
	localparam logic [CODE_W-1:0] CODE_STOP = 8'd40;
	localparam logic [CODE_W-1:0] CODE_R_A = 8'd47;
	localparam logic [CODE_W-1:0] CODE_R_B = 8'd48;
	localparam logic [CODE_W-1:0] CODE_S_A = 8'd49;
	localparam logic [CODE_W-1:0] CODE_S_B = 8'd50;

	typedef struct packed {
		logic [1:0] opcode;
		logic [TIME_BITS-1:0] ann_time;
		logic [CODE_W-1:0] ann_code;
	} in_beat_t;

	typedef struct packed {
		logic [BPM_W-1:0] interval_bpm_q8;
		logic interval_valid;
		logic s_peak_mode;
		logic record_done;
	} out_beat_t;

	function automatic logic is_r_code(input logic [CODE_W-1:0] c);
		return (c == CODE_R_A) || (c == CODE_R_B);
	endfunction

	function automatic logic is_s_code(input logic [CODE_W-1:0] c);
		return (c == CODE_S_A) || (c == CODE_S_B);
	endfunction

	function automatic logic is_skip_code(input logic [CODE_W-1:0] c);
		return c inside {8'd0, 8'd15, 8'd36, 8'd37, 8'd40, [8'd17:8'd33], [8'd42:8'd45],
			[8'd47:8'd50]};
	endfunction

endpackage

@@ hw/rtl/rri_ram.sv @@
// generic single port ram with registered read
module rri_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ hw/rtl/rri_div.sv @@
// radix-2 restoring divider for the bpm quotient
module rri_div #(
	parameter int unsigned NUM_W = 30,
	parameter int unsigned DEN_W = 24
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [NUM_W-1:0] num,
	input logic [DEN_W-1:0] den,
	output logic busy,
	output logic [NUM_W-1:0] quot
);
	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0] rem_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;

	assign trial = {rem_q[DEN_W-1:0], quot_q[NUM_W-1]};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quot_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff;
				quot_q <= {quot_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quot_q <= {quot_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quot_q;
endmodule

@@ hw/rtl/ecg_rr_interval_extractor_core.sv @@
// top level of the beat interval extractor
// one beat is accepted at a time. a load or clear is done without leaving idle, so loads can
// follow back to back. a fetch walks the stored annotations through one combined time/code
// memory: each visited entry is read and then decoded, a beat with a previous beat adds eight
// lookahead reads, each through a read state and a lookahead state, and then a check, and
// an accepted interval adds a run of the bit-serial divider before its result. a fetch result
// waits in the output register until taken; a later fetch holds its own result until then.
// clear resets the counters and the walk and beat state only; the store needs no clearing pass.
module ecg_rr_interval_extractor_core #(
	parameter int unsigned MAX_ANNOTATIONS = rri_pkg::MAX_ANN_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [rri_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [rri_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input rri_pkg::in_beat_t in_data,
	output logic out_valid,
	input logic out_stall,
	output rri_pkg::out_beat_t out_data
);
	import rri_pkg::*;

	localparam int unsigned AW = $clog2(MAX_ANNOTATIONS);
	localparam int unsigned CW = AW + 1;
	localparam int unsigned MW = TIME_BITS + CODE_W;
	localparam int unsigned NUM_W = 30;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD = 4'd1;
	localparam logic [3:0] ST_CODE = 4'd2;
	localparam logic [3:0] ST_LA_RD = 4'd3;
	localparam logic [3:0] ST_LA = 4'd4;
	localparam logic [3:0] ST_CHECK = 4'd5;
	localparam logic [3:0] ST_DIV = 4'd6;
	localparam logic [3:0] ST_DIVW = 4'd7;
	localparam logic [3:0] ST_OUT = 4'd8;

	logic [15:0] rate_q;
	logic [9:0] min_q;
	logic [9:0] max_q;
	logic [3:0] st_q;
	logic [CW-1:0] loaded_q;
	logic [CW-1:0] rcnt_q;
	logic [CW-1:0] scnt_q;
	logic [CW-1:0] walk_q;
	logic [CW-1:0] prev_q;
	logic prev_ok_q;
	logic [TIME_BITS-1:0] fid1_q;
	logic [TIME_BITS-1:0] fid2_q;
	logic smode_q;
	logic [CW-1:0] cur_q;
	// lookahead control: which beat (0 current, 1 previous), offset 0..3
	logic side_q;
	logic [1:0] off_q;
	logic [TIME_BITS-1:0] t0_q;
	logic found_q;
	logic fixed_q;
	logic [3:0] rank_q;
	logic [TIME_BITS-1:0] pick_q;
	logic [BPM_W-1:0] bpm_q;
	logic ovalid_q;
	out_beat_t obeat_q;

	logic mem_we;
	logic [AW-1:0] mem_addr;
	logic [MW-1:0] mem_wdata;
	logic [MW-1:0] mem_rdata;
	logic [TIME_BITS-1:0] rd_time;
	logic [CODE_W-1:0] rd_code;
	logic [CW-1:0] base_idx;
	logic [CW-1:0] la_idx;
	logic la_in;
	logic [3:0] rank;
	logic [TIME_BITS:0] delta;
	logic [TIME_BITS-1:0] den;
	logic [21:0] num;
	logic [TIME_BITS+10:0] lo_prod;
	logic [TIME_BITS+10:0] hi_prod;
	logic div_start;
	logic div_busy;
	logic [NUM_W-1:0] quot;
	logic in_acc;

	assign rd_time = mem_rdata[MW-1:CODE_W];
	assign rd_code = mem_rdata[CODE_W-1:0];
	assign in_acc = in_valid && !in_stall;
	assign in_stall = st_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= 16'd360;
			min_q <= 10'd20;
			max_q <= 10'd300;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SAMPLE_RATE: rate_q <= cfg_data;
				REG_MIN_BPM: min_q <= cfg_data[9:0];
				REG_MAX_BPM: max_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign base_idx = side_q ? prev_q : cur_q;
	assign la_idx = base_idx + CW'(off_q);
	assign la_in = la_idx < loaded_q;

	// lookahead priority rank, lower is better; 15 means no match
	always_comb begin
		rank = 4'd15;
		if (la_in && off_q != 2'd0) begin
			if (!smode_q) begin
				if (is_r_code(rd_code) && off_q != 2'd3) begin
					rank = {2'b00, off_q};
				end
			end else begin
				if (is_s_code(rd_code)) begin
					rank = {2'b00, off_q};
				end else if (is_r_code(rd_code) && off_q != 2'd3) begin
					rank = 4'd3 + {2'b00, off_q};
				end
			end
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_addr = walk_q[AW-1:0];
		mem_wdata = {in_data.ann_time, in_data.ann_code};
		if (st_q == ST_IDLE && in_acc && in_data.opcode == OP_LOAD &&
			loaded_q < CW'(MAX_ANNOTATIONS)) begin
			mem_we = 1'b1;
			mem_addr = loaded_q[AW-1:0];
		end else if (st_q == ST_LA_RD || st_q == ST_LA) begin
			mem_addr = la_idx[AW-1:0];
		end
	end

	rri_ram #(.WIDTH(MW), .DEPTH(MAX_ANNOTATIONS)) u_store (
		.clk(clk),
		.we(mem_we),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	assign delta = {1'b0, fid2_q} - {1'b0, fid1_q};
	assign den = delta[TIME_BITS-1:0];
	assign num = 22'(rate_q) * 22'd60;
	assign lo_prod = (TIME_BITS+11)'(min_q) * (TIME_BITS+11)'(den);
	assign hi_prod = (TIME_BITS+11)'(max_q) * (TIME_BITS+11)'(den);
	assign div_start = st_q == ST_DIV;

	rri_div #(.NUM_W(NUM_W), .DEN_W(TIME_BITS)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num({num, 8'd0}),
		.den(den),
		.busy(div_busy),
		.quot(quot)
	);

	always_ff @(posedge clk) begin
		if (st_q == ST_LA && off_q == 2'd0) begin
			t0_q <= rd_time;
		end
		if (st_q == ST_LA && rank < rank_q) begin
			pick_q <= rd_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			loaded_q <= '0;
			rcnt_q <= '0;
			scnt_q <= '0;
			walk_q <= '0;
			prev_q <= '0;
			prev_ok_q <= 1'b0;
			fid1_q <= '0;
			fid2_q <= '0;
			smode_q <= 1'b0;
			cur_q <= '0;
			side_q <= 1'b0;
			off_q <= '0;
			found_q <= 1'b0;
			fixed_q <= 1'b0;
			rank_q <= 4'd15;
			bpm_q <= '0;
			ovalid_q <= 1'b0;
			obeat_q <= '0;
		end else begin
			if (ovalid_q && !out_stall) begin
				ovalid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						smode_q <= ({4'd0, rcnt_q} * 4'd11) < ({4'd0, scnt_q} * 4'd10);
						found_q <= 1'b0;
						case (in_data.opcode)
							OP_LOAD: begin
								if (loaded_q < CW'(MAX_ANNOTATIONS)) begin
									loaded_q <= loaded_q + 1'b1;
									if (is_r_code(in_data.ann_code)) begin
										rcnt_q <= rcnt_q + 1'b1;
									end else if (is_s_code(in_data.ann_code)) begin
										scnt_q <= scnt_q + 1'b1;
									end
								end
							end
							OP_CLEAR: begin
								loaded_q <= '0;
								rcnt_q <= '0;
								scnt_q <= '0;
								walk_q <= '0;
								prev_q <= '0;
								prev_ok_q <= 1'b0;
								fid1_q <= '0;
								fid2_q <= '0;
							end
							OP_FETCH: begin
								st_q <= ST_RD;
							end
							default: ;
						endcase
					end
				end
				ST_RD: begin
					if (walk_q < loaded_q) begin
						cur_q <= walk_q;
						walk_q <= walk_q + 1'b1;
						st_q <= ST_CODE;
					end else begin
						st_q <= ST_OUT;
					end
				end
				ST_CODE: begin
					if (rd_code == CODE_NOISE_A || rd_code == CODE_NOISE_B) begin
						prev_ok_q <= 1'b0;
						st_q <= ST_RD;
					end else if (is_skip_code(rd_code)) begin
						st_q <= ST_RD;
					end else if (prev_ok_q) begin
						side_q <= 1'b0;
						off_q <= '0;
						rank_q <= 4'd15;
						fixed_q <= 1'b0;
						st_q <= ST_LA_RD;
					end else begin
						prev_q <= cur_q;
						prev_ok_q <= 1'b1;
						st_q <= ST_RD;
					end
				end
				ST_LA_RD: begin
					st_q <= ST_LA;
				end
				ST_LA: begin
					if (off_q == 2'd1 && smode_q && la_in && rd_code == CODE_STOP) begin
						fixed_q <= 1'b1;
					end
					if (rank < rank_q) begin
						rank_q <= rank;
					end
					if (off_q != 2'd3) begin
						off_q <= off_q + 1'b1;
						st_q <= ST_LA_RD;
					end else begin
						if (!side_q) begin
							fid2_q <= fixed_q ? t0_q : (rank < rank_q ? rd_time :
								(rank_q != 4'd15 ? pick_q : (smode_q ? fid2_q : t0_q)));
							side_q <= 1'b1;
							off_q <= '0;
							rank_q <= 4'd15;
							fixed_q <= 1'b0;
							st_q <= ST_LA_RD;
						end else begin
							fid1_q <= fixed_q ? t0_q : (rank < rank_q ? rd_time :
								(rank_q != 4'd15 ? pick_q : (smode_q ? fid1_q : t0_q)));
							st_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					prev_q <= cur_q;
					prev_ok_q <= 1'b1;
					if (!delta[TIME_BITS] && den != '0 &&
						lo_prod <= (TIME_BITS+11)'(num) && (TIME_BITS+11)'(num) <= hi_prod) begin
						st_q <= ST_DIV;
					end else begin
						st_q <= ST_RD;
					end
				end
				ST_DIV: begin
					st_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (!div_busy) begin
						bpm_q <= quot[BPM_W-1:0];
						found_q <= 1'b1;
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						obeat_q.interval_bpm_q8 <= found_q ? bpm_q : '0;
						obeat_q.interval_valid <= found_q;
						obeat_q.s_peak_mode <= smode_q;
						obeat_q.record_done <= walk_q >= loaded_q;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// code read for the walk happens in ST_RD with addr walk_q
	assign out_valid = ovalid_q;
	assign out_data = obeat_q;

`ifndef SYNTHESIS
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n) walk_q <= loaded_q)
		else $error("walk index past loaded count");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_IDLE |-> in_stall)
		else $error("input taken while busy");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIV |=> div_busy)
		else $error("divider did not start");
	a_valid_bpm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.interval_valid |-> out_data.interval_bpm_q8 == '0)
		else $error("bpm without valid interval");
`endif
endmodule
